// ----- rtl/msblt_pkg.sv -----
// Package for the bounded-list table: constants, codes, item structs, FSM states.
// No dependencies.
package msblt_pkg;

  localparam int SLOTS   = 10;
  localparam int MAX_CAP = 16;
  localparam int SLOT_W  = 4;
  localparam int CAP_W   = $clog2(MAX_CAP + 1);
  localparam int POS_W   = (MAX_CAP > 1) ? $clog2(MAX_CAP) : 1;
  localparam int DEPTH   = SLOTS * MAX_CAP;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0, ACT_APPEND = 3'd1, ACT_DROP = 3'd2, ACT_DELETE = 3'd3,
    ACT_RESIZE = 3'd4, ACT_COUNT = 3'd5, ACT_READ = 3'd6, ACT_READ_SORTED = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_BAD_SLOT = 4'd1, ST_EXISTS = 4'd2, ST_BAD_SIZE = 4'd3,
    ST_OVER_MAX = 4'd4, ST_NO_SLOT = 4'd5, ST_FULL = 4'd6, ST_EMPTY = 4'd7,
    ST_ABSENT = 4'd8, ST_BAD_NEW = 4'd9
  } status_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         slot;
    logic signed [31:0] value;
    logic signed [7:0]  size_amount;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [31:0] data;
    logic [6:0]         count;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_LOAD_W, S_SCAN, S_SORT_A, S_SORT_B, S_EMIT, S_RESP
  } state_t;

  // memory address of element pos in slot index idx
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] idx,
                                                  input logic [POS_W-1:0] pos);
    logic [31:0] a;
    a = 32'(idx) * 32'(MAX_CAP) + 32'(pos);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/msblt_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module msblt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/multi_slot_bounded_list_table_core.sv -----
// Bounded-list table: 10 slots of up to 16 signed words, words in one RAM (msblt_ram, msblt_pkg).
// Simple actions: result valid in the cycle after the item; next item once that result is taken.
// Delete: loads the words, then moves each word after the match down one place; read: loads, then emits.
// Sorted read adds compare-and-swap steps plus index steps before the words are emitted.
// One item in flight; the RAM's single read port sets the walk rate.
// Reset (rst_n, synchronous): all slots unused; the word RAM is not cleared.
module multi_slot_bounded_list_table_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msblt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msblt_pkg::out_item_t out_data
);
  import msblt_pkg::*;

  // slot descriptors in flops
  logic             used_r [SLOTS];
  logic [CAP_W-1:0] cap_r  [SLOTS];
  logic [CAP_W-1:0] cnt_r  [SLOTS];

  state_t state_r, state_nxt;
  in_item_t req_r;
  logic [IDX_W-1:0] idx_r;
  logic [CAP_W-1:0] n_r;          // count at request start
  logic [CAP_W-1:0] i_r, j_r;     // walk positions
  logic [CAP_W-1:0] hit_r;
  logic             found_r;
  logic             ovalid_r;
  out_item_t        odata_r;
  logic signed [31:0] buf_r [MAX_CAP];

  // RAM ports
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0]       wdata, rdata;

  msblt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  logic accept;
  assign accept = in_valid && in_ready;

  // decode of the incoming item
  logic             slot_ok;
  logic [IDX_W-1:0] in_idx;
  logic [3:0]       slot_m1;
  assign slot_ok = (in_data.slot >= 4'd1) && (32'(in_data.slot) <= SLOTS);
  assign slot_m1 = in_data.slot - 4'd1;
  assign in_idx  = slot_m1[IDX_W-1:0];

  logic [CAP_W-1:0] c_cnt, c_cap;
  logic             c_used;
  assign c_cnt  = cnt_r[in_idx];
  assign c_cap  = cap_r[in_idx];
  assign c_used = used_r[in_idx];

  logic signed [9:0] ncap;
  assign ncap = 10'(signed'({1'b0, c_cap})) + 10'(in_data.size_amount);

  // walk logic signals
  logic signed [31:0] bi, bj;
  assign bi = buf_r[i_r[POS_W-1:0]];
  assign bj = buf_r[j_r[POS_W-1:0]];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && slot_ok && c_used && c_cnt != '0 &&
            (in_data.action inside {ACT_DELETE, ACT_READ, ACT_READ_SORTED}))
          state_nxt = S_LOAD;
      end
      S_LOAD:   state_nxt = S_LOAD_W;
      S_LOAD_W: begin
        if (j_r + 1'b1 == n_r) begin
          if (req_r.action == ACT_DELETE) state_nxt = S_SCAN;
          else if (req_r.action == ACT_READ_SORTED) state_nxt = S_SORT_A;
          else state_nxt = S_EMIT;
        end else state_nxt = S_LOAD;
      end
      S_SCAN: if (!found_r || (i_r + 1'b1 >= n_r)) state_nxt = S_IDLE;
      S_SORT_A: if (i_r + 1'b1 >= n_r) state_nxt = S_EMIT;
      S_EMIT: if ((!ovalid_r || out_ready) && (i_r + 1'b1 == n_r)) state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        used_r[k] <= 1'b0; cap_r[k] <= '0; cnt_r[k] <= '0;
      end
    end else begin
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (accept) begin
          req_r <= in_data;
          idx_r <= in_idx;
          n_r   <= c_cnt;
          odata_r.data <= '0;
          odata_r.last <= 1'b1;
          odata_r.count <= 7'(c_cnt);
          odata_r.status <= ST_OK;
          if (!slot_ok) begin
            odata_r.status <= ST_BAD_SLOT; odata_r.count <= '0; ovalid_r <= 1'b1;
          end else if (in_data.action == ACT_CREATE) begin
            ovalid_r <= 1'b1;
            if (c_used) odata_r.status <= ST_EXISTS;
            else begin
              odata_r.count <= '0;
              if (in_data.size_amount < 8'sd1) odata_r.status <= ST_BAD_SIZE;
              else if (32'(in_data.size_amount) > MAX_CAP) odata_r.status <= ST_OVER_MAX;
              else begin
                used_r[in_idx] <= 1'b1;
                cap_r[in_idx]  <= CAP_W'(in_data.size_amount);
                cnt_r[in_idx]  <= '0;
              end
            end
          end else if (!c_used) begin
            odata_r.status <= ST_NO_SLOT; odata_r.count <= '0; ovalid_r <= 1'b1;
          end else begin
            case (action_t'(in_data.action))
              ACT_APPEND: begin
                ovalid_r <= 1'b1;
                if (c_cnt >= c_cap) odata_r.status <= ST_FULL;
                else begin
                  cnt_r[in_idx] <= c_cnt + 1'b1;
                  odata_r.count <= 7'(c_cnt + 1'b1);
                end
              end
              ACT_DROP, ACT_COUNT: begin
                ovalid_r <= 1'b1;
                if (c_cnt == '0) odata_r.status <= ST_EMPTY;
                else if (in_data.action == ACT_DROP) begin
                  cnt_r[in_idx] <= c_cnt - 1'b1;
                  odata_r.count <= 7'(c_cnt - 1'b1);
                end
              end
              ACT_RESIZE: begin
                ovalid_r <= 1'b1;
                if (ncap < 10'sd1) odata_r.status <= ST_BAD_NEW;
                else if (ncap > 10'(MAX_CAP)) odata_r.status <= ST_OVER_MAX;
                else begin
                  cap_r[in_idx] <= CAP_W'(ncap);
                  if (32'(c_cnt) > 32'(ncap)) begin
                    cnt_r[in_idx] <= CAP_W'(ncap);
                    odata_r.count <= 7'(ncap);
                  end
                end
              end
              default: begin
                // delete / read: load words into the buffer first
                if (c_cnt == '0) begin
                  if (in_data.action == ACT_DELETE) odata_r.status <= ST_EMPTY;
                  ovalid_r <= 1'b1;
                end else begin
                  i_r <= '0; j_r <= '0; found_r <= 1'b0;
                end
              end
            endcase
          end
        end
        // read address i_r issued (raddr comb); data arrives next cycle
        S_LOAD: begin
          i_r <= i_r + 1'b1;
        end
        S_LOAD_W: begin
          buf_r[j_r[POS_W-1:0]] <= rdata;
          if (!found_r && rdata == req_r.value) begin
            found_r <= 1'b1; hit_r <= j_r;
          end
          if (j_r + 1'b1 == n_r && req_r.action == ACT_READ_SORTED) j_r <= CAP_W'(1);
          else j_r <= j_r + 1'b1;
          if (j_r + 1'b1 == n_r) begin
            if (req_r.action == ACT_DELETE)
              i_r <= (!found_r && rdata == req_r.value) ? j_r : hit_r;
            else i_r <= '0;
          end
        end
        // compaction: write buf[i+1] to position i, one word a cycle
        S_SCAN: begin
          if (!found_r) begin
            odata_r.status <= ST_ABSENT; ovalid_r <= 1'b1;
          end else if (i_r + 1'b1 >= n_r) begin
            cnt_r[idx_r] <= n_r - 1'b1;
            odata_r.count <= 7'(n_r - 1'b1);
            ovalid_r <= 1'b1;
          end else i_r <= i_r + 1'b1;
        end
        // selection sort over the buffer, one compare per cycle apart from the steps to the next i
        S_SORT_A: begin
          if (i_r + 1'b1 >= n_r) begin
            i_r <= '0;
          end else if (j_r >= n_r) begin
            i_r <= i_r + 1'b1; j_r <= i_r + 2'd2;
          end else begin
            if (bi > bj) begin
              buf_r[i_r[POS_W-1:0]] <= bj;
              buf_r[j_r[POS_W-1:0]] <= bi;
            end
            j_r <= j_r + 1'b1;
          end
        end
        // one result per word
        S_EMIT: if (!ovalid_r || out_ready) begin
          odata_r.status <= ST_OK;
          odata_r.data   <= bi;
          odata_r.count  <= 7'(n_r);
          odata_r.last   <= (i_r + 1'b1 == n_r);
          ovalid_r <= 1'b1;
          i_r <= i_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // RAM access
  always_comb begin
    we    = 1'b0;
    wdata = in_data.value;
    waddr = elem_addr(in_idx, c_cnt[POS_W-1:0]);
    raddr = elem_addr(idx_r, i_r[POS_W-1:0]);
    if (state_r == S_IDLE && accept && slot_ok && c_used &&
        in_data.action == ACT_APPEND && c_cnt < c_cap) we = 1'b1;
    if (state_r == S_SCAN && found_r && (i_r + 1'b1 < n_r)) begin
      we    = 1'b1;
      waddr = elem_addr(idx_r, i_r[POS_W-1:0]);
      wdata = buf_r[POS_W'(i_r + 1'b1)];
    end
  end

`ifndef SYNTHESIS
  // no item is taken while a result is pending or a walk runs
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == S_IDLE && !out_valid))
    else $error("item accepted while busy");
  // the count of the first slot never exceeds its capacity while idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r[0] <= cap_r[0]))
    else $error("slot count above capacity");
  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");
`endif
endmodule

// ----- test/multi_slot_bounded_list_table_core_tb.sv -----
// Testbench for multi_slot_bounded_list_table_core: random and directed list requests,
// results checked against an in-bench model of the slot table. Depends on msblt_pkg and the core.
`timescale 1ns / 1ps

module multi_slot_bounded_list_table_core_tb;
  import msblt_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  multi_slot_bounded_list_table_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // table model state
  logic               tbl_used [SLOTS];
  int                 tbl_cap  [SLOTS];
  int                 tbl_cnt  [SLOTS];
  logic signed [31:0] tbl_words[SLOTS][MAX_CAP];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int  mismatches;
  int  results_seen;
  int  items_sent;
  int  stall_cycles;
  int  idle_cycles;
  bit  quiet_phase;
  bit  hold_sender;

  function automatic out_item_t mk_res(status_t st, logic signed [31:0] d, int c, bit l);
    out_item_t r;
    r.status = st;
    r.data   = d;
    r.count  = 7'(c);
    r.last   = l;
    return r;
  endfunction

  // apply one request to the model and queue the results it causes
  function automatic void table_apply(in_item_t it);
    int                 ix, c, cap, k, j, ncap, amt;
    logic signed [31:0] buf_w[MAX_CAP];
    logic signed [31:0] t;
    amt = int'(it.size_amount);
    if (it.slot < 1 || it.slot > SLOTS) begin
      expected_results.push_back(mk_res(ST_BAD_SLOT, 0, 0, 1));
      return;
    end
    ix = it.slot - 1;
    if (action_t'(it.action) == ACT_CREATE) begin
      if (tbl_used[ix]) expected_results.push_back(mk_res(ST_EXISTS, 0, tbl_cnt[ix], 1));
      else if (amt < 1) expected_results.push_back(mk_res(ST_BAD_SIZE, 0, 0, 1));
      else if (amt > MAX_CAP) expected_results.push_back(mk_res(ST_OVER_MAX, 0, 0, 1));
      else begin
        tbl_used[ix] = 1;
        tbl_cap[ix]  = amt;
        tbl_cnt[ix]  = 0;
        expected_results.push_back(mk_res(ST_OK, 0, 0, 1));
      end
      return;
    end
    if (!tbl_used[ix]) begin
      expected_results.push_back(mk_res(ST_NO_SLOT, 0, 0, 1));
      return;
    end
    c   = tbl_cnt[ix];
    cap = tbl_cap[ix];
    case (action_t'(it.action))
      ACT_APPEND: begin
        if (c >= cap) expected_results.push_back(mk_res(ST_FULL, 0, c, 1));
        else begin
          tbl_words[ix][c] = it.value;
          tbl_cnt[ix] = c + 1;
          expected_results.push_back(mk_res(ST_OK, 0, c + 1, 1));
        end
      end
      ACT_DROP: begin
        if (c == 0) expected_results.push_back(mk_res(ST_EMPTY, 0, 0, 1));
        else begin
          tbl_cnt[ix] = c - 1;
          expected_results.push_back(mk_res(ST_OK, 0, c - 1, 1));
        end
      end
      ACT_DELETE: begin
        if (c == 0) expected_results.push_back(mk_res(ST_EMPTY, 0, 0, 1));
        else begin
          for (k = 0; k < c; k++) if (tbl_words[ix][k] == it.value) break;
          if (k == c) expected_results.push_back(mk_res(ST_ABSENT, 0, c, 1));
          else begin
            for (; k + 1 < c; k++) tbl_words[ix][k] = tbl_words[ix][k + 1];
            tbl_cnt[ix] = c - 1;
            expected_results.push_back(mk_res(ST_OK, 0, c - 1, 1));
          end
        end
      end
      ACT_RESIZE: begin
        ncap = cap + amt;
        if (ncap < 1) expected_results.push_back(mk_res(ST_BAD_NEW, 0, c, 1));
        else if (ncap > MAX_CAP) expected_results.push_back(mk_res(ST_OVER_MAX, 0, c, 1));
        else begin
          tbl_cap[ix] = ncap;
          if (c > ncap) c = ncap;
          tbl_cnt[ix] = c;
          expected_results.push_back(mk_res(ST_OK, 0, c, 1));
        end
      end
      ACT_COUNT:
        expected_results.push_back(mk_res(c == 0 ? ST_EMPTY : ST_OK, 0, c, 1));
      default: begin
        if (c == 0) expected_results.push_back(mk_res(ST_OK, 0, 0, 1));
        else begin
          for (k = 0; k < c; k++) buf_w[k] = tbl_words[ix][k];
          if (action_t'(it.action) == ACT_READ_SORTED)
            for (k = 0; k + 1 < c; k++)
              for (j = k + 1; j < c; j++)
                if (buf_w[k] > buf_w[j]) begin
                  t = buf_w[k]; buf_w[k] = buf_w[j]; buf_w[j] = t;
                end
          for (k = 0; k < c; k++)
            expected_results.push_back(mk_res(ST_OK, buf_w[k], c, k + 1 == c));
        end
      end
    endcase
  endfunction

  function automatic in_item_t mk_item(action_t a, int s, logic signed [31:0] v, int amt);
    in_item_t it;
    it.action      = a;
    it.slot        = 4'(s);
    it.value       = v;
    it.size_amount = 8'(amt);
    return it;
  endfunction

  // random word: full range, near the extremes, or from a small pool so deletes hit
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return 32'sh7fff_ffff - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 12)) - 6;
    endcase
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) items_sent <= items_sent + 1;
      if (pending_items.size() > 0 && !hold_sender &&
          (quiet_phase || $urandom_range(0, 99) >= 15)) begin
        in_valid <= 1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) table_apply(in_data);
  end

  // receiver ready, with a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      out_ready <= 0;
    end else out_ready <= quiet_phase || $urandom_range(0, 99) >= 15;
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status || out_data.data !== want.data ||
            out_data.count !== want.count || out_data.last !== want.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result differs: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // watchdog on cycles without any acceptance
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("multi_slot_bounded_list_table_core: mismatch");
        $finish;
      end
    end
  end

  // sampled at the falling edge, when queues and handshakes have settled
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
  endtask

  // stimulus
  initial begin
    int n, s, a;
    rst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
    mismatches = 0; results_seen = 0; items_sent = 0;
    stall_cycles = 0; idle_cycles = 0; quiet_phase = 0; hold_sender = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 0; tbl_cap[i] = 0; tbl_cnt[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: bad slots, sizes, every action, edge values
    pending_items.push_back(mk_item(ACT_CREATE, 0, 0, 4));
    pending_items.push_back(mk_item(ACT_READ, 15, 0, 4));
    pending_items.push_back(mk_item(ACT_APPEND, 2, 1, 0));
    pending_items.push_back(mk_item(ACT_CREATE, 1, 0, 0));
    pending_items.push_back(mk_item(ACT_CREATE, 1, 0, -128));
    pending_items.push_back(mk_item(ACT_CREATE, 1, 0, 17));
    pending_items.push_back(mk_item(ACT_CREATE, 1, 0, 127));
    pending_items.push_back(mk_item(ACT_CREATE, 1, 0, 3));
    pending_items.push_back(mk_item(ACT_CREATE, 1, 0, 3));
    pending_items.push_back(mk_item(ACT_COUNT, 1, 0, 0));
    pending_items.push_back(mk_item(ACT_READ, 1, 0, 0));
    pending_items.push_back(mk_item(ACT_DROP, 1, 0, 0));
    pending_items.push_back(mk_item(ACT_DELETE, 1, 5, 0));
    pending_items.push_back(mk_item(ACT_APPEND, 1, 32'sh7fffffff, 0));
    pending_items.push_back(mk_item(ACT_APPEND, 1, 32'sh80000000, 0));
    pending_items.push_back(mk_item(ACT_APPEND, 1, -1, 0));
    pending_items.push_back(mk_item(ACT_APPEND, 1, 7, 0));
    pending_items.push_back(mk_item(ACT_READ_SORTED, 1, 0, 0));
    pending_items.push_back(mk_item(ACT_DELETE, 1, 3, 0));
    pending_items.push_back(mk_item(ACT_DELETE, 1, -1, 0));
    pending_items.push_back(mk_item(ACT_RESIZE, 1, 0, -128));
    pending_items.push_back(mk_item(ACT_RESIZE, 1, 0, 127));
    pending_items.push_back(mk_item(ACT_RESIZE, 1, 0, -2));
    pending_items.push_back(mk_item(ACT_RESIZE, 1, 0, 15));
    pending_items.push_back(mk_item(ACT_CREATE, SLOTS, 0, 16));
    wait_drained();

    // receiver holds off long while the sender keeps offering
    for (int i = 0; i < 10; i++)
      pending_items.push_back(mk_item(ACT_APPEND, SLOTS, rand_word(), 0));
    pending_items.push_back(mk_item(ACT_READ, SLOTS, 0, 0));
    stall_cycles = 300;
    wait_drained();

    // random mix, mostly well-formed on valid slots; quiet stretch in the middle
    for (n = 0; n < 95; n++) begin
      if (n == 40) quiet_phase = 1;
      if (n == 70) quiet_phase = 0;
      if (n == 80) begin
        // sender pauses until the block is drained
        wait_drained();
        hold_sender = 1;
        repeat (20) @(posedge clk);
        hold_sender = 0;
      end
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      a = $urandom_range(0, 99);
      if (a < 40) pending_items.push_back(mk_item(ACT_APPEND, s, rand_word(), $urandom));
      else if (a < 48) pending_items.push_back(mk_item(ACT_CREATE, s, $urandom,
                                                 $urandom_range(0, 3) == 0 ? $urandom
                                                 : $urandom_range(1, 16)));
      else if (a < 56) pending_items.push_back(mk_item(ACT_DROP, s, $urandom, $urandom));
      else if (a < 68) pending_items.push_back(mk_item(ACT_DELETE, s, rand_word(), $urandom));
      else if (a < 76) pending_items.push_back(mk_item(ACT_RESIZE, s, $urandom,
                                                 $urandom_range(0, 3) == 0 ? $urandom
                                                 : $signed($urandom_range(0, 16)) - 8));
      else if (a < 82) pending_items.push_back(mk_item(ACT_COUNT, s, $urandom, $urandom));
      else if (a < 91) pending_items.push_back(mk_item(ACT_READ, s, $urandom, $urandom));
      else pending_items.push_back(mk_item(ACT_READ_SORTED, s, $urandom, $urandom));
      while (pending_items.size() > 4) @(posedge clk);
    end
    wait_drained();
    repeat (100) @(posedge clk);

    $display("covered %0d requests and %0d results across create, append, drop, delete,",
             items_sent, results_seen);
    $display("resize, count and both read orders, with back-pressure and idle gaps");
    if (mismatches == 0 && expected_results.size() == 0)
      $display("multi_slot_bounded_list_table_core: match");
    else
      $display("multi_slot_bounded_list_table_core: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/msblt_pkg.sv
rtl/msblt_ram.sv
rtl/multi_slot_bounded_list_table_core.sv
test/multi_slot_bounded_list_table_core_tb.sv
